// ===== rtl/scsa_pkg.sv =====
package scsa_pkg;

  // Field widths of the channels and registers
  localparam int MODE_W        = 3;
  localparam int INDEX_W       = 12;
  localparam int COLUMN_W      = 16;
  localparam int VALUE_W       = 64;
  localparam int STATUS_W      = 2;
  localparam int SLOT_W        = 12;
  localparam int ROW_COUNT_W   = 9;
  localparam int ENTRY_COUNT_W = 13;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 13;

  // Default storage sizes
  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_MAX_SLOTS = 4096;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_ROW  = 3'd0,
    MODE_LOAD_COL  = 3'd1,
    MODE_ADD_MAT   = 3'd2,
    MODE_ADD_VEC   = 3'd3,
    MODE_SET_VEC   = 3'd4,
    MODE_READ_SLOT = 3'd5,
    MODE_READ_VEC  = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_COUNT   = 1'b0,
    REG_ENTRY_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ROW_LO,
    ST_ROW_HI,
    ST_SCAN,
    ST_MAT_ADD,
    ST_VEC_RD,
    ST_SLOT_RD,
    ST_DONE
  } state_t;

  // Strobes into the slot store
  typedef struct packed {
    logic rd_en;
    logic col_we;
    logic val_we;
  } slot_ctl_t;

  // Q32.32 add clamped to the signed 64-bit range
  function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    logic [VALUE_W-1:0] r;
    r = a + b;
    if ((a[VALUE_W-1] == b[VALUE_W-1]) && (r[VALUE_W-1] != a[VALUE_W-1])) begin
      r = a[VALUE_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/scsa_if.sv =====
interface scsa_in_if;
  import scsa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [INDEX_W-1:0]        index;
  logic [COLUMN_W-1:0]       column;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, index, column, value, input ready);
  modport sink   (input valid, mode, index, column, value, output ready);
endinterface

interface scsa_out_if;
  import scsa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [SLOT_W-1:0]         slot;
  logic signed [VALUE_W-1:0] read_value;

  modport source (output valid, status, slot, read_value, input ready);
  modport sink   (input valid, status, slot, read_value, output ready);
endinterface

// ===== rtl/scsa_slot_mem.sv =====
module scsa_slot_mem #(
  parameter int  SLOTS   = scsa_pkg::DEF_MAX_SLOTS,
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                           clk,
  input  scsa_pkg::slot_ctl_t            ctl,
  input  logic [SLOT_AW-1:0]             rd_addr,
  input  logic [SLOT_AW-1:0]             wr_addr,
  input  logic [scsa_pkg::COLUMN_W-1:0]  col_wdata,
  input  logic [scsa_pkg::VALUE_W-1:0]   val_wdata,
  output logic [scsa_pkg::COLUMN_W-1:0]  col_rdata_r,
  output logic [scsa_pkg::VALUE_W-1:0]   val_rdata_r
);
  import scsa_pkg::*;

  logic [COLUMN_W-1:0] col_mem [SLOTS];
  logic [VALUE_W-1:0]  val_mem [SLOTS];

  // Column store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.col_we) begin
      col_mem[wr_addr] <= col_wdata;
    end
    if (ctl.rd_en) begin
      col_rdata_r <= col_mem[rd_addr];
    end
  end

  // Value store: read alongside the column so a hit has its operand at once
  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[wr_addr] <= val_wdata;
    end
    if (ctl.rd_en) begin
      val_rdata_r <= val_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sparse_csr_scatter_accumulate_unit.sv =====
// Channel  | Direction | Handshake       | Beat payload
// in_ch    | in        | valid / ready   | mode, index, column, value
// out_ch   | out       | valid / ready   | status, slot, read_value
// cfg_*    | in        | cfg_we (no ack) | cfg_index, cfg_wdata
//
// One item at a time. Loads and set-vector finish in the dispatch state; vector add, vector
// read and slot read do one memory read first, and a vector add then adds and writes back.
// A matrix add reads the row's start and end, then scans its column slots (one slot-store
// read per cycle) up to and including the hit, then adds and writes; a miss scans them all.
// After reset a clearing pass zeroes the value stores over max(MAX_ROWS, MAX_SLOTS) addresses,
// with in_ch.ready low. A stalled out_ch holds one result in the output register; the block
// then parks the next result until the register frees.
module sparse_csr_scatter_accumulate_unit #(
  parameter int MAX_ROWS  = scsa_pkg::DEF_MAX_ROWS,
  parameter int MAX_SLOTS = scsa_pkg::DEF_MAX_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  scsa_in_if.sink                         in_ch,
  scsa_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [scsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import scsa_pkg::*;

  localparam int RS_DEPTH = MAX_ROWS + 1;
  localparam int RS_AW    = $clog2(RS_DEPTH);
  localparam int VEC_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SLOT_AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OFF_W    = $clog2(MAX_SLOTS + 1);
  localparam int NROW_W   = $clog2(MAX_ROWS + 1);
  localparam int CLR_N    = (MAX_ROWS > MAX_SLOTS) ? MAX_ROWS : MAX_SLOTS;
  localparam int CLR_W    = $clog2(CLR_N + 1);

  // Control state
  state_t                   state_r, state_nxt;
  logic [CLR_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [ROW_COUNT_W-1:0]   row_count_r;
  logic [ENTRY_COUNT_W-1:0] entry_count_r;

  // Item and scan registers
  logic [MODE_W-1:0]        mode_r;
  logic [INDEX_W-1:0]       idx_r;
  logic [COLUMN_W-1:0]      col_r;
  logic [VALUE_W-1:0]       val_r;
  logic [OFF_W-1:0]         scan_i_r, scan_i_nxt;
  logic [OFF_W-1:0]         lim_r, lim_nxt;
  logic [SLOT_AW-1:0]       pend_addr_r, pend_addr_nxt;

  // Pending result and output register
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]        res_slot_r, res_slot_nxt;
  logic [VALUE_W-1:0]       res_value_r, res_value_nxt;
  logic [STATUS_W-1:0]      out_status_r;
  logic [SLOT_W-1:0]        out_slot_r;
  logic [VALUE_W-1:0]       out_value_r;
  logic                     out_load;

  // Row start and vector memories
  logic [OFF_W-1:0]         rs_mem [RS_DEPTH];
  logic [VALUE_W-1:0]       vec_mem [MAX_ROWS];
  logic                     rs_we, rs_re;
  logic [RS_AW-1:0]         rs_waddr, rs_raddr;
  logic [OFF_W-1:0]         rs_rdata_r;
  logic                     vec_we, vec_re;
  logic [VEC_AW-1:0]        vec_addr;
  logic [VALUE_W-1:0]       vec_wdata;
  logic [VALUE_W-1:0]       vec_rdata_r;

  // Slot store port
  slot_ctl_t                slot_ctl;
  logic [SLOT_AW-1:0]       slot_raddr, slot_waddr;
  logic [VALUE_W-1:0]       slot_val_wdata;
  logic [COLUMN_W-1:0]      slot_col_rd;
  logic [VALUE_W-1:0]       slot_val_rd;

  // Derived values
  logic                     take;
  logic [NROW_W-1:0]        nrows;
  logic [OFF_W-1:0]         nslots;
  logic                     idx_le_rows, idx_lt_rows, idx_lt_slots;
  logic [OFF_W-1:0]         off_clamp;
  logic                     scan_hit;
  logic [VALUE_W-1:0]       add_a, add_sum;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign take              = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.read_value = out_value_r;

  // Rows and slots in use, clipped to the storage
  assign nrows  = (32'(row_count_r) < 32'(MAX_ROWS)) ? NROW_W'(row_count_r)
                                                      : NROW_W'(MAX_ROWS);
  assign nslots = (32'(entry_count_r) < 32'(MAX_SLOTS)) ? OFF_W'(entry_count_r)
                                                         : OFF_W'(MAX_SLOTS);
  assign idx_le_rows  = 32'(idx_r) <= 32'(nrows);
  assign idx_lt_rows  = 32'(idx_r) <  32'(nrows);
  assign idx_lt_slots = 32'(idx_r) <  32'(nslots);

  // Clamp a row start offset into 0..MAX_SLOTS
  assign off_clamp = val_r[VALUE_W-1]           ? '0 :
                     (val_r > 64'(MAX_SLOTS))   ? OFF_W'(MAX_SLOTS) :
                                                  OFF_W'(val_r);

  assign scan_hit = pend_r && (slot_col_rd == col_r);

  // One saturating adder shared by matrix and vector adds
  assign add_a   = (state_r == ST_MAT_ADD) ? slot_val_rd : vec_rdata_r;
  assign add_sum = sat_add(add_a, val_r);

  // Next state, memory strobes and result
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    scan_i_nxt     = scan_i_r;
    lim_nxt        = lim_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_value_nxt  = res_value_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    rs_we          = 1'b0;
    rs_re          = 1'b0;
    rs_waddr       = RS_AW'(idx_r);
    rs_raddr       = RS_AW'(idx_r);
    vec_we         = 1'b0;
    vec_re         = 1'b0;
    vec_addr       = VEC_AW'(idx_r);
    vec_wdata      = val_r;
    slot_ctl       = '0;
    slot_raddr     = SLOT_AW'(idx_r);
    slot_waddr     = SLOT_AW'(idx_r);
    slot_val_wdata = add_sum;

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep both value stores to zero
        vec_addr       = clr_cnt_r[VEC_AW-1:0];
        vec_wdata      = '0;
        vec_we         = 32'(clr_cnt_r) < 32'(MAX_ROWS);
        slot_waddr     = clr_cnt_r[SLOT_AW-1:0];
        slot_val_wdata = '0;
        slot_ctl.val_we = 32'(clr_cnt_r) < 32'(MAX_SLOTS);
        clr_cnt_nxt    = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        // Reject by default; each legal mode overrides
        res_status_nxt = STAT_RANGE;
        res_slot_nxt   = '0;
        res_value_nxt  = '0;
        state_nxt      = ST_DONE;
        unique case (mode_t'(mode_r)) inside
          MODE_LOAD_ROW: begin
            if (idx_le_rows) begin
              rs_we          = 1'b1;
              res_status_nxt = STAT_OK;
              res_value_nxt  = VALUE_W'(off_clamp);
            end
          end
          MODE_LOAD_COL: begin
            if (idx_lt_slots) begin
              slot_ctl.col_we = 1'b1;
              res_status_nxt  = STAT_OK;
              res_value_nxt   = VALUE_W'(col_r);
            end
          end
          MODE_ADD_MAT: begin
            if (idx_lt_rows) begin
              rs_re     = 1'b1;
              state_nxt = ST_ROW_LO;
            end
          end
          MODE_ADD_VEC, MODE_READ_VEC: begin
            if (idx_lt_rows) begin
              vec_re    = 1'b1;
              state_nxt = ST_VEC_RD;
            end
          end
          MODE_SET_VEC: begin
            if (idx_lt_rows) begin
              vec_we         = 1'b1;
              res_status_nxt = STAT_OK;
              res_value_nxt  = val_r;
            end
          end
          MODE_READ_SLOT: begin
            if (idx_lt_slots) begin
              slot_ctl.rd_en = 1'b1;
              state_nxt      = ST_SLOT_RD;
            end
          end
          default: begin
          end
        endcase
      end

      ST_ROW_LO: begin
        // Row start is back; fetch the next row's start
        scan_i_nxt = rs_rdata_r;
        rs_re      = 1'b1;
        rs_raddr   = RS_AW'(idx_r) + 1'b1;
        state_nxt  = ST_ROW_HI;
      end

      ST_ROW_HI: begin
        lim_nxt   = (rs_rdata_r < nslots) ? rs_rdata_r : nslots;
        pend_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        // Check the slot read last cycle; without a hit, fetch the next one
        if (scan_hit) begin
          state_nxt = ST_MAT_ADD;
        end else if (scan_i_r < lim_r) begin
          slot_ctl.rd_en = 1'b1;
          slot_raddr     = scan_i_r[SLOT_AW-1:0];
          pend_nxt       = 1'b1;
          pend_addr_nxt  = scan_i_r[SLOT_AW-1:0];
          scan_i_nxt     = scan_i_r + 1'b1;
        end else begin
          res_status_nxt = STAT_MISS;
          res_slot_nxt   = '0;
          res_value_nxt  = '0;
          state_nxt      = ST_DONE;
        end
      end

      ST_MAT_ADD: begin
        slot_ctl.val_we = 1'b1;
        slot_waddr      = pend_addr_r;
        res_status_nxt  = STAT_OK;
        res_slot_nxt    = SLOT_W'(pend_addr_r);
        res_value_nxt   = add_sum;
        state_nxt       = ST_DONE;
      end

      ST_VEC_RD: begin
        res_status_nxt = STAT_OK;
        res_slot_nxt   = '0;
        if (mode_t'(mode_r) == MODE_ADD_VEC) begin
          vec_we        = 1'b1;
          vec_wdata     = add_sum;
          res_value_nxt = add_sum;
        end else begin
          res_value_nxt = vec_rdata_r;
        end
        state_nxt = ST_DONE;
      end

      ST_SLOT_RD: begin
        res_status_nxt = STAT_OK;
        res_slot_nxt   = '0;
        res_value_nxt  = slot_val_rd;
        state_nxt      = ST_DONE;
      end

      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      row_count_r   <= '0;
      entry_count_r <= '0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ROW_COUNT:   row_count_r   <= cfg_wdata[ROW_COUNT_W-1:0];
          REG_ENTRY_COUNT: entry_count_r <= cfg_wdata[ENTRY_COUNT_W-1:0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_ch.mode;
      idx_r  <= in_ch.index;
      col_r  <= in_ch.column;
      val_r  <= in_ch.value;
    end
    scan_i_r     <= scan_i_nxt;
    lim_r        <= lim_nxt;
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_value_r  <= res_value_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_value_r  <= res_value_r;
    end
  end

  // Row start memory
  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= off_clamp;
    end
    if (rs_re) begin
      rs_rdata_r <= rs_mem[rs_raddr];
    end
  end

  // Vector memory
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_addr] <= vec_wdata;
    end
    if (vec_re) begin
      vec_rdata_r <= vec_mem[vec_addr];
    end
  end

  scsa_slot_mem #(
    .SLOTS (MAX_SLOTS)
  ) u_slot_mem (
    .clk         (clk),
    .ctl         (slot_ctl),
    .rd_addr     (slot_raddr),
    .wr_addr     (slot_waddr),
    .col_wdata   (col_r),
    .val_wdata   (slot_val_wdata),
    .col_rdata_r (slot_col_rd),
    .val_rdata_r (slot_val_rd)
  );

  // A column hit is written back in the very next cycle
  a_hit_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_hit) |=> (state_r == ST_MAT_ADD && slot_ctl.val_we))
    else $error("column hit not followed by slot write-back");

  // An accepted beat always starts decoding next cycle
  a_take_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (state_r == ST_DISPATCH))
    else $error("accepted beat not dispatched");

  // A result appears only from the hand-over state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside hand-over");

  // The write-back address is one that the scan has fetched
  a_add_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAT_ADD) |-> (pend_r && $past(scan_hit)))
    else $error("matrix add without a pending slot");

endmodule
